### hdl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, register indexes, reset values and saturation helpers for
// the clamped PI regulator.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned FracW = 16;
  localparam int unsigned CfgAddrW = 2;

  typedef logic signed [DataW-1:0] q16_t;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_P_GAIN  = 2'd0,
    REG_I_GAIN  = 2'd1,
    REG_OUT_MAX = 2'd2,
    REG_OUT_MIN = 2'd3
  } cfg_reg_t;

  localparam q16_t P_GAIN_RST  = 32'sh0000_0000;
  localparam q16_t I_GAIN_RST  = 32'sh0000_0000;
  localparam q16_t OUT_MAX_RST = 32'sh7FFF_FFFF;
  localparam q16_t OUT_MIN_RST = 32'sh8000_0000;
  localparam q16_t Q_MAX       = 32'sh7FFF_FFFF;
  localparam q16_t Q_MIN       = 32'sh8000_0000;

  // integrator control flags carried from input to integrator stage
  typedef struct packed {
    logic i_hold;
    logic i_force;
  } integ_ctl_t;

  // limit flags of one result
  typedef struct packed {
    logic integ_at_min;
    logic integ_at_max;
    logic drive_at_min;
    logic drive_at_max;
  } lim_flags_t;

  // saturate a floored product (48 significant bits) to 32 bits
  function automatic q16_t sat_prod(input logic signed [ProdW-FracW-1:0] v);
    logic upper_same;
    upper_same = (v[ProdW-FracW-1:DataW-1] == {(ProdW-FracW-DataW+1){1'b0}})
              || (v[ProdW-FracW-1:DataW-1] == {(ProdW-FracW-DataW+1){1'b1}});
    if (upper_same) begin
      return v[DataW-1:0];
    end else if (v[ProdW-FracW-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

  // saturate a 33-bit sum to 32 bits
  function automatic q16_t sat_sum(input logic signed [DataW:0] v);
    if (v[DataW] == v[DataW-1]) begin
      return v[DataW-1:0];
    end else if (v[DataW]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

### hdl/pic_qmul.sv
// ----------------------------------------------------------------------------
// pic_qmul
// Registered Q16.16 multiplier: floor shift by 16, saturate to 32 bits,
// optional forced zero.
// ----------------------------------------------------------------------------
module pic_qmul (
  input  logic           clk,
  input  logic           en,
  input  pic_pkg::q16_t  a,
  input  pic_pkg::q16_t  b,
  input  logic           zero,
  output pic_pkg::q16_t  q_r
);

  logic signed [pic_pkg::ProdW-1:0] prod;
  pic_pkg::q16_t                    q_nxt;

  // arithmetic select of the upper bits is the floor of prod / 2^16
  assign prod  = a * b;
  assign q_nxt = zero ? '0
               : pic_pkg::sat_prod(prod[pic_pkg::ProdW-1:pic_pkg::FracW]);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

### hdl/pic_integ.sv
// ----------------------------------------------------------------------------
// pic_integ
// Controller state: proportional part and clamped integrator with
// anti-windup (no accumulation outside the limits).
// ----------------------------------------------------------------------------
module pic_integ (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  pic_pkg::q16_t       prop_in,
  input  pic_pkg::q16_t       iprod,
  input  pic_pkg::q16_t       preload,
  input  pic_pkg::integ_ctl_t ctl,
  input  pic_pkg::q16_t       lim_max,
  input  pic_pkg::q16_t       lim_min,
  output pic_pkg::q16_t       prop_state_r,
  output pic_pkg::q16_t       integ_state_r
);

  pic_pkg::q16_t               base;
  pic_pkg::q16_t               acc_val;
  pic_pkg::q16_t               hi_clamped;
  pic_pkg::q16_t               integ_nxt;
  logic                        in_lim;
  logic                        do_acc;
  logic signed [pic_pkg::DataW:0] sum;

  assign base    = ctl.i_force ? preload : integ_state_r;
  assign in_lim  = (base >= lim_min) && (base <= lim_max);
  assign do_acc  = !ctl.i_hold && !ctl.i_force && in_lim;
  assign sum     = {base[pic_pkg::DataW-1], base} + {iprod[pic_pkg::DataW-1], iprod};
  assign acc_val = do_acc ? pic_pkg::sat_sum(sum) : base;
  // upper clamp first, lower clamp last: with inverted limits the minimum wins
  assign hi_clamped = (acc_val > lim_max) ? lim_max : acc_val;
  assign integ_nxt  = (hi_clamped < lim_min) ? lim_min : hi_clamped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_state_r  <= '0;
      integ_state_r <= '0;
    end else if (en) begin
      prop_state_r  <= prop_in;
      integ_state_r <= integ_nxt;
    end
  end

endmodule

### hdl/pic_out.sv
// ----------------------------------------------------------------------------
// pic_out
// Output stage: saturated sum of both parts, limited, with limit flags,
// held in the result register.
// ----------------------------------------------------------------------------
module pic_out (
  input  logic                clk,
  input  logic                en,
  input  pic_pkg::q16_t       prop,
  input  pic_pkg::q16_t       integ,
  input  pic_pkg::q16_t       lim_max,
  input  pic_pkg::q16_t       lim_min,
  output pic_pkg::q16_t       drive_r,
  output pic_pkg::q16_t       prop_r,
  output pic_pkg::q16_t       integ_r,
  output pic_pkg::lim_flags_t flags_r
);

  logic signed [pic_pkg::DataW:0] sum;
  pic_pkg::q16_t                  sat_val;
  pic_pkg::q16_t                  drive_nxt;
  pic_pkg::lim_flags_t            flags_nxt;

  assign sum     = {prop[pic_pkg::DataW-1], prop} + {integ[pic_pkg::DataW-1], integ};
  assign sat_val = pic_pkg::sat_sum(sum);

  // upper limit tested first: inverted limits give max above it, else min
  always_comb begin
    if (sat_val > lim_max) begin
      drive_nxt = lim_max;
    end else if (sat_val < lim_min) begin
      drive_nxt = lim_min;
    end else begin
      drive_nxt = sat_val;
    end
    flags_nxt.drive_at_max = (drive_nxt == lim_max);
    flags_nxt.drive_at_min = (drive_nxt == lim_min);
    flags_nxt.integ_at_max = (integ == lim_max);
    flags_nxt.integ_at_min = (integ == lim_min);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drive_r <= drive_nxt;
      prop_r  <= prop;
      integ_r <= integ;
      flags_r <= flags_nxt;
    end
  end

endmodule

### hdl/pi_controller_clamped_integrator_top.sv
// ----------------------------------------------------------------------------
// pi_controller_clamped_integrator_top
// Discrete PI regulator, signed Q16.16, clamping anti-windup.
// ----------------------------------------------------------------------------
// Usage: one control error sample per in_ transfer, with the p_off, i_hold
// and i_force flags on in_tuser and the integrator preload in in_tdata.
// Every transfer in gives exactly one transfer out carrying the limited
// drive, the proportional and integrator parts and four limit flags.
// Pipeline: input register, two multipliers, state register (integrator
// update), result register. Throughput is one sample per cycle while the
// receiver does not stall; the integrator update is a single add, compare
// and clamp around its own register, so consecutive samples never wait
// for one another. Gains and limits are written through cfg_; the user
// must do so only while no sample is in flight, the block does not check.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes both state
// parts and loads the register defaults: zero gains, full-range limits.
// When a result waits on a stalled receiver, the whole pipeline holds and
// in_tready drops; it advances again in the cycle out_tready returns.
// ----------------------------------------------------------------------------
module pi_controller_clamped_integrator_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] error_in, [63:32] i_preload
  input  logic [2:0]  in_tuser,   // [0] p_off, [1] i_hold, [2] i_force
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] drive, [63:32] prop_part, [95:64] integ_part
  output logic [3:0]  out_tuser,  // [0] drive_at_max, [1] drive_at_min,
                                  // [2] integ_at_max, [3] integ_at_min
  // configuration write port
  input  logic        cfg_we,
  input  logic [pic_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  pic_pkg::q16_t p_gain_r, i_gain_r, out_max_r, out_min_r;

  // pipeline control
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;

  // stage 1: input register
  pic_pkg::q16_t       s1_err_r, s1_preload_r;
  logic                s1_p_off_r;
  pic_pkg::integ_ctl_t s1_ctl_r;

  // stage 2: products
  pic_pkg::q16_t       s2_prop, s2_iprod, s2_preload_r;
  pic_pkg::integ_ctl_t s2_ctl_r;

  // stage 3: controller state
  pic_pkg::q16_t       prop_state, integ_state;

  // result register
  pic_pkg::q16_t       drive_q, prop_q, integ_q;
  pic_pkg::lim_flags_t flags_q;

  // whole pipeline moves when the result register is empty or being taken
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r  <= pic_pkg::P_GAIN_RST;
      i_gain_r  <= pic_pkg::I_GAIN_RST;
      out_max_r <= pic_pkg::OUT_MAX_RST;
      out_min_r <= pic_pkg::OUT_MIN_RST;
    end else if (cfg_we) begin
      case (pic_pkg::cfg_reg_t'(cfg_addr))
        pic_pkg::REG_P_GAIN:  p_gain_r  <= cfg_wdata;
        pic_pkg::REG_I_GAIN:  i_gain_r  <= cfg_wdata;
        pic_pkg::REG_OUT_MAX: out_max_r <= cfg_wdata;
        pic_pkg::REG_OUT_MIN: out_min_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // input register: payload only
  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      s1_err_r           <= in_tdata[31:0];
      s1_preload_r       <= in_tdata[63:32];
      s1_p_off_r         <= in_tuser[0];
      s1_ctl_r.i_hold    <= in_tuser[1];
      s1_ctl_r.i_force   <= in_tuser[2];
    end
  end

  // side band carried alongside the products
  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      s2_preload_r <= s1_preload_r;
      s2_ctl_r     <= s1_ctl_r;
    end
  end

  pic_qmul u_pmul (
    .clk  (clk),
    .en   (adv && s1_vld_r),
    .a    (p_gain_r),
    .b    (s1_err_r),
    .zero (s1_p_off_r),
    .q_r  (s2_prop)
  );

  pic_qmul u_imul (
    .clk  (clk),
    .en   (adv && s1_vld_r),
    .a    (i_gain_r),
    .b    (s1_err_r),
    .zero (1'b0),
    .q_r  (s2_iprod)
  );

  // state advances once per sample
  pic_integ u_integ (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv && s2_vld_r),
    .prop_in       (s2_prop),
    .iprod         (s2_iprod),
    .preload       (s2_preload_r),
    .ctl           (s2_ctl_r),
    .lim_max       (out_max_r),
    .lim_min       (out_min_r),
    .prop_state_r  (prop_state),
    .integ_state_r (integ_state)
  );

  pic_out u_out (
    .clk     (clk),
    .en      (adv && s3_vld_r),
    .prop    (prop_state),
    .integ   (integ_state),
    .lim_max (out_max_r),
    .lim_min (out_min_r),
    .drive_r (drive_q),
    .prop_r  (prop_q),
    .integ_r (integ_q),
    .flags_r (flags_q)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {integ_q, prop_q, drive_q};
  assign out_tuser  = {flags_q.integ_at_min, flags_q.integ_at_max,
                       flags_q.drive_at_min, flags_q.drive_at_max};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a stalled result must freeze the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while result stalled");

  // integrator only moves when a sample passes the state stage
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s2_vld_r) |=> $stable(integ_state))
    else $error("integrator changed without a sample");

  // with ordered limits the updated integrator lies inside them
  a_integ_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r && (out_min_r <= out_max_r)) |=>
      ((integ_state >= $past(out_min_r)) && (integ_state <= $past(out_max_r))))
    else $error("integrator outside limits");

  // a held result must not change
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule
